FILE: rtl/core/gdd_pkg.sv
package gdd_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int DGAIN_W    = 15;
   localparam int KGAIN_W    = 16;
   localparam int SIZE_W     = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_DIFFUSION_GAIN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_GAIN     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_LENGTH     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW_COUNT      = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd3;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;

   // classified item with the five stencil taps
   typedef struct packed {
      logic [SAMPLE_W-1:0] ctr;
      logic [SAMPLE_W-1:0] up;
      logic [SAMPLE_W-1:0] down;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                pass1;
      logic                has1;
      logic                has2;
      logic                fend2;
   } gdd_operand_type;

   // one or two results waiting for the output side
   typedef struct packed {
      logic [SAMPLE_W-1:0] v1;
      logic                has1;
      logic [SAMPLE_W-1:0] v2;
      logic                has2;
      logic                fend2;
   } gdd_entry_type;

endpackage

FILE: rtl/core/gdd_front.sv
module gdd_front #(
   parameter int MAX_ROW_LEN = 1024,
   parameter int MAX_ROWS    = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [gdd_pkg::SAMPLE_W-1:0]         sample,
   input  logic                                 frame_start,
   input  logic [$clog2(MAX_ROW_LEN):0]         len,
   input  logic [$clog2(MAX_ROWS):0]            rows,
   output logic                                 op_valid,
   output gdd_pkg::gdd_operand_type             op
);

   localparam int CW = $clog2(MAX_ROW_LEN);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int SW = gdd_pkg::SAMPLE_W;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [CW:0]   c0, c1, cn;
   logic [RW:0]   r0, r1, r2, rp;
   logic [CW-1:0] col_cur, col_right;
   logic          has1_cur, has2_cur, pass1_cur, fend2_cur;

   logic [SW-1:0] newer_row_mem [MAX_ROW_LEN];
   logic [SW-1:0] older_row_mem [MAX_ROW_LEN];
   logic [SW-1:0] newer_rd0_ff, newer_rd1_ff, older_rd_ff;

   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [SW-1:0] s1_x_ff;
   logic          s1_pass1_ff, s1_has1_ff, s1_has2_ff, s1_fend2_ff;
   logic          byp_ff;
   logic [SW-1:0] byp_val_ff;
   logic [SW-1:0] left_ff;

   // raster position of the arriving sample and of the one after it
   always_comb begin
      c0 = frame_start ? '0 : {1'b0, col_ff};
      r0 = frame_start ? '0 : {1'b0, row_ff};
      if (c0 >= len) begin
         c1 = '0;
         r1 = r0 + 1'b1;
      end else begin
         c1 = c0;
         r1 = r0;
      end
      r2        = (r1 >= rows) ? '0 : r1;
      col_cur   = c1[CW-1:0];
      col_right = col_cur + 1'b1;
      cn        = c1 + 1'b1;
      rp        = r2 + 1'b1;
      if (cn >= len) begin
         col_in = '0;
         row_in = (rp >= rows) ? '0 : rp[RW-1:0];
      end else begin
         col_in = cn[CW-1:0];
         row_in = r2[RW-1:0];
      end
      has1_cur  = (r2 != '0);
      has2_cur  = (r2 == rows - 1'b1);
      fend2_cur = (c1 == len - 1'b1);
      pass1_cur = (r2 == (RW+1)'(1)) || (c1 == '0) || fend2_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         newer_rd0_ff <= newer_row_mem[col_cur];
         newer_rd1_ff <= newer_row_mem[col_right];
         newer_row_mem[col_cur] <= sample;
      end
   end

   // the older row takes the displaced newer value in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         older_rd_ff <= older_row_mem[col_cur];
      end
      if (s1_valid_ff) begin
         older_row_mem[s1_col_ff] <= newer_rd0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col_cur;
         s1_x_ff     <= sample;
         s1_pass1_ff <= pass1_cur;
         s1_has1_ff  <= has1_cur;
         s1_has2_ff  <= has2_cur;
         s1_fend2_ff <= fend2_cur;
         // older write still in flight at the same column
         byp_ff      <= s1_valid_ff && (col_cur == s1_col_ff);
         byp_val_ff  <= newer_rd0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (s1_valid_ff) begin
         left_ff <= newer_rd0_ff;
      end
   end

   always_comb begin
      op_valid = s1_valid_ff && (s1_has1_ff || s1_has2_ff);
      op.ctr   = newer_rd0_ff;
      op.up    = byp_ff ? byp_val_ff : older_rd_ff;
      op.down  = s1_x_ff;
      op.left  = left_ff;
      op.right = newer_rd1_ff;
      op.pass1 = s1_pass1_ff;
      op.has1  = s1_has1_ff;
      op.has2  = s1_has2_ff;
      op.fend2 = s1_fend2_ff;
   end

endmodule

FILE: rtl/core/gdd_stencil.sv
module gdd_stencil (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              op_valid,
   input  gdd_pkg::gdd_operand_type          op,
   input  logic [gdd_pkg::DGAIN_W-1:0]       diffusion_gain,
   input  logic [gdd_pkg::KGAIN_W-1:0]       decay_gain,
   output logic                              push,
   output gdd_pkg::gdd_entry_type            push_entry,
   output logic [2:0]                        busy
);

   localparam int SW = gdd_pkg::SAMPLE_W;

   typedef struct packed {
      logic [SW-1:0] ctr;
      logic [SW-1:0] x;
      logic          pass1;
      logic          has1;
      logic          has2;
      logic          fend2;
   } tag_type;

   tag_type            tag_in;
   logic               st2_valid_ff, st3_valid_ff, st4_valid_ff;
   tag_type            st2_tag_ff, st3_tag_ff, st4_tag_ff;

   logic [33:0]        st2_sum_in, st2_sum_ff;
   logic [18:0]        k_wide;
   logic [17:0]        st2_k_ff;
   logic signed [49:0] st3_p1_in, st3_p2_in, st3_p1_ff, st3_p2_ff;
   logic signed [51:0] st4_acc_in, st4_acc_ff;
   logic [35:0]        shifted;
   logic [SW-1:0]      sat;

   always_comb begin
      tag_in.ctr   = op.ctr;
      tag_in.x     = op.down;
      tag_in.pass1 = op.pass1;
      tag_in.has1  = op.has1;
      tag_in.has2  = op.has2;
      tag_in.fend2 = op.fend2;
      st2_sum_in   = {{2{op.up[SW-1]}}, op.up} + {{2{op.down[SW-1]}}, op.down}
                   + {{2{op.left[SW-1]}}, op.left} + {{2{op.right[SW-1]}}, op.right};
      // center weight 1 - 4a - b in Q.16
      k_wide       = 19'h10000 - {2'b00, diffusion_gain, 2'b00} - {3'b000, decay_gain};
   end

   always_comb begin
      st3_p1_in  = $signed(st2_tag_ff.ctr) * $signed(st2_k_ff);
      st3_p2_in  = $signed({1'b0, diffusion_gain}) * $signed(st2_sum_ff);
      st4_acc_in = 52'(st3_p1_ff) + 52'(st3_p2_ff) + 52'sd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
      end else begin
         st2_valid_ff <= op_valid;
         st3_valid_ff <= st2_valid_ff;
         st4_valid_ff <= st3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      st2_tag_ff <= tag_in;
      st2_sum_ff <= st2_sum_in;
      st2_k_ff   <= k_wide[17:0];
      st3_tag_ff <= st2_tag_ff;
      st3_p1_ff  <= st3_p1_in;
      st3_p2_ff  <= st3_p2_in;
      st4_tag_ff <= st3_tag_ff;
      st4_acc_ff <= st4_acc_in;
   end

   // drop the 16 extra fraction bits and clip to 32 bits
   always_comb begin
      shifted = st4_acc_ff[51:16];
      if (shifted[35:31] == 5'b00000 || shifted[35:31] == 5'b11111) begin
         sat = shifted[SW-1:0];
      end else if (shifted[35]) begin
         sat = 32'h8000_0000;
      end else begin
         sat = 32'h7FFF_FFFF;
      end
   end

   always_comb begin
      push             = st4_valid_ff;
      push_entry.v1    = st4_tag_ff.pass1 ? st4_tag_ff.ctr : sat;
      push_entry.has1  = st4_tag_ff.has1;
      push_entry.v2    = st4_tag_ff.x;
      push_entry.has2  = st4_tag_ff.has2;
      push_entry.fend2 = st4_tag_ff.fend2;
      busy             = {st4_valid_ff, st3_valid_ff, st2_valid_ff};
   end

endmodule

FILE: rtl/core/gdd_fifo.sv
module gdd_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  gdd_pkg::gdd_entry_type         push_entry,
   input  logic                           pop,
   output gdd_pkg::gdd_entry_type         head,
   output logic                           empty,
   output logic [gdd_pkg::FIFO_AW:0]      count
);

   localparam int AW = gdd_pkg::FIFO_AW;

   gdd_pkg::gdd_entry_type entry_ff [gdd_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

FILE: rtl/core/gdd_emit.sv
module gdd_emit (
   input  logic                             clock,
   input  logic                             reset,
   input  gdd_pkg::gdd_entry_type           head,
   input  logic                             empty,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gdd_pkg::SAMPLE_W-1:0]     rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);

   localparam int SW = gdd_pkg::SAMPLE_W;

   logic          valid_ff, valid_in;
   logic          sub_ff, sub_in;
   logic [SW-1:0] value_ff, value_in;
   logic          last_ff, last_in;
   logic          fend_ff, fend_in;
   logic          load, done;

   // first result is the row above, second is the own passthrough
   always_comb begin
      load = !empty && (!valid_ff || rsp_tready);
      if (head.has1 && !sub_ff) begin
         value_in = head.v1;
         last_in  = !head.has2;
         fend_in  = 1'b0;
         done     = !head.has2;
      end else begin
         value_in = head.v2;
         last_in  = 1'b1;
         fend_in  = head.fend2;
         done     = 1'b1;
      end
      pop      = load && done;
      sub_in   = load ? !done : sub_ff;
      valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         last_ff  <= last_in;
         fend_ff  <= fend_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = fend_ff;

endmodule

FILE: rtl/core/grid_diffusion_decay_step.sv
// path: a cell's result reaches rsp_tdata after the sample one row below is accepted
//   (buffer read on that edge, 3 arithmetic stages, queue, output register)
// throughput: one sample per cycle while req_tready is high; on the last row each sample
//   yields two results, so the output port sets the pace there
// reset: synchronous; clears position, pipeline and queue; gains to 0, sizes to 1024;
//   line buffers keep their contents
module grid_diffusion_decay_step #(
   parameter int MAX_ROW_LEN = 1024,
   parameter int MAX_ROWS    = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gdd_pkg::SAMPLE_W-1:0]       req_tdata,   // [31:0] sample
   input  logic                               req_tuser,   // [0] frame_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gdd_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [31:0] value
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,   // [0] frame_end
   input  logic                               csr_we,
   input  logic [gdd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [gdd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LW = $clog2(MAX_ROW_LEN) + 1;
   localparam int NW = $clog2(MAX_ROWS) + 1;
   localparam int AW = gdd_pkg::FIFO_AW;

   logic [gdd_pkg::DGAIN_W-1:0] diffusion_gain_ff;
   logic [gdd_pkg::KGAIN_W-1:0] decay_gain_ff;
   logic [gdd_pkg::SIZE_W-1:0]  row_length_ff, row_count_ff;

   logic [LW-1:0] len;
   logic [NW-1:0] rows;

   logic                     accept;
   logic                     op_valid;
   gdd_pkg::gdd_operand_type op;
   logic                     push;
   gdd_pkg::gdd_entry_type   push_entry, head;
   logic [2:0]               busy;
   logic                     pop, empty;
   logic [AW:0]              count;
   logic [AW+1:0]            used;

   always_ff @(posedge clock) begin
      if (reset) begin
         diffusion_gain_ff <= '0;
         decay_gain_ff     <= '0;
         row_length_ff     <= gdd_pkg::SIZE_RESET;
         row_count_ff      <= gdd_pkg::SIZE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            gdd_pkg::CSR_DIFFUSION_GAIN: diffusion_gain_ff <= csr_wdata[gdd_pkg::DGAIN_W-1:0];
            gdd_pkg::CSR_DECAY_GAIN:     decay_gain_ff     <= csr_wdata[gdd_pkg::KGAIN_W-1:0];
            gdd_pkg::CSR_ROW_LENGTH:     row_length_ff     <= csr_wdata[gdd_pkg::SIZE_W-1:0];
            gdd_pkg::CSR_ROW_COUNT:      row_count_ff      <= csr_wdata[gdd_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // sizes clamped to the supported range
   always_comb begin
      if (row_length_ff < gdd_pkg::SIZE_MIN) begin
         len = LW'(3);
      end else if (32'(row_length_ff) > 32'(MAX_ROW_LEN)) begin
         len = LW'(MAX_ROW_LEN);
      end else begin
         len = LW'(row_length_ff);
      end
      if (row_count_ff < gdd_pkg::SIZE_MIN) begin
         rows = NW'(3);
      end else if (32'(row_count_ff) > 32'(MAX_ROWS)) begin
         rows = NW'(MAX_ROWS);
      end else begin
         rows = NW'(row_count_ff);
      end
   end

   // queue slots are reserved for every item still in the pipeline
   always_comb begin
      used       = (AW+2)'(count) + (AW+2)'($countones({busy, op_valid}));
      req_tready = (used < (AW+2)'(gdd_pkg::FIFO_DEPTH));
      accept     = req_tvalid && req_tready;
   end

   gdd_front #(
      .MAX_ROW_LEN (MAX_ROW_LEN),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .sample      (req_tdata),
      .frame_start (req_tuser),
      .len         (len),
      .rows        (rows),
      .op_valid    (op_valid),
      .op          (op)
   );

   gdd_stencil u_stencil (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (op_valid),
      .op             (op),
      .diffusion_gain (diffusion_gain_ff),
      .decay_gain     (decay_gain_ff),
      .push           (push),
      .push_entry     (push_entry),
      .busy           (busy)
   );

   gdd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .count      (count)
   );

   gdd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: bench/grid_diffusion_decay_step_tb.sv
`timescale 1ns / 100ps

module grid_diffusion_decay_step_tb;

   localparam int          MAX_ROW_LEN    = 1024;
   localparam int          MAX_ROWS       = 1024;
   localparam longint      STENCIL_WEIGHT = 4;
   localparam longint      SAT_HI         = 64'sh0000_0000_7FFF_FFFF;
   localparam longint      SAT_LO         = 64'shFFFF_FFFF_8000_0000;
   localparam int          RANDOM_ITEMS   = 1175;
   localparam int          QUIET_CYCLES   = 16;
   localparam int unsigned CYCLE_LIMIT    = 1_000_000;
   localparam int          REPORT_CAP     = 40;

   typedef struct packed {
      logic [gdd_pkg::SAMPLE_W-1:0] value;
      logic                         run_last;
      logic                         frame_end;
   } cell_result_type;

   // raw register words, one per csr index
   typedef struct {
      logic [gdd_pkg::CSR_DATA_W-1:0] diffusion;
      logic [gdd_pkg::CSR_DATA_W-1:0] decay;
      logic [gdd_pkg::CSR_DATA_W-1:0] length;
      logic [gdd_pkg::CSR_DATA_W-1:0] count;
   } grid_setting_type;

   typedef struct {
      int            setting;      // -1 keeps the current registers
      logic [31:0]   sample;
      logic          frame_start;
      bit            typed;        // expected results given below
      int            count;
      logic [31:0]   v0;
      logic          l0;
      logic          e0;
      logic [31:0]   v1;
      logic          l1;
      logic          e1;
   } directed_row_type;

   typedef enum int {PACE_OPEN, PACE_COIN, PACE_QUARTER, PACE_MOSTLY} pace_mode_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [gdd_pkg::SAMPLE_W-1:0]    req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b1;
   logic [gdd_pkg::SAMPLE_W-1:0]    rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [gdd_pkg::CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [gdd_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   grid_diffusion_decay_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // predictor copy of the registers and the grid state
   logic [gdd_pkg::DGAIN_W-1:0]    diffusion_gain = '0;
   logic [gdd_pkg::KGAIN_W-1:0]    decay_gain     = '0;
   logic [gdd_pkg::SIZE_W-1:0]     row_length     = gdd_pkg::SIZE_RESET;
   logic [gdd_pkg::SIZE_W-1:0]     row_count      = gdd_pkg::SIZE_RESET;
   logic signed [31:0]     older_rows [MAX_ROW_LEN];
   logic signed [31:0]     newer_rows [MAX_ROW_LEN];
   bit                     older_ok   [MAX_ROW_LEN];
   bit                     newer_ok   [MAX_ROW_LEN];
   int unsigned            col_pos   = 0;
   int unsigned            row_pos   = 0;
   logic signed [31:0]     left_hold = '0;

   cell_result_type        pending_cells [$];
   int unsigned            cycle_count   = 0;
   int unsigned            mismatches    = 0;
   int unsigned            samples_sent  = 0;
   int unsigned            cells_checked = 0;
   int unsigned            settings_used = 0;
   int                     burst_left    = 0;

   grid_setting_type directed_settings [3] = '{
      '{16'd0,     16'd0,     16'd3, 16'd3},
      '{16'd16384, 16'd65535, 16'd4, 16'd3},
      '{16'd1,     16'd1,     16'd0, 16'd1}
   };

   directed_row_type directed_rows [25] = '{
      // 3x3 frame with zero gains, every result readable
      '{ 0, 32'h7FFF_FFFF, 1'b1, 1, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h8000_0000, 1'b0, 1, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h0000_0000, 1'b0, 1, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'hFFFF_FFFF, 1'b0, 1, 1, 32'h7FFF_FFFF, 1, 0, 32'h0, 0, 0},
      '{-1, 32'h0001_0000, 1'b0, 1, 1, 32'h8000_0000, 1, 0, 32'h0, 0, 0},
      '{-1, 32'h5555_5555, 1'b0, 1, 1, 32'h0000_0000, 1, 0, 32'h0, 0, 0},
      '{-1, 32'hAAAA_AAAA, 1'b0, 1, 2, 32'hFFFF_FFFF, 0, 0, 32'hAAAA_AAAA, 1, 0},
      '{-1, 32'h1234_5678, 1'b0, 1, 2, 32'h0001_0000, 0, 0, 32'h1234_5678, 1, 0},
      '{-1, 32'hFEDC_BA98, 1'b0, 1, 2, 32'h5555_5555, 0, 0, 32'hFEDC_BA98, 1, 1},
      // 4x3 frame at full gains, wraps in without frame_start, saturates both ways
      '{ 1, 32'h4000_0000, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h7FFF_FFFF, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h8000_0000, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h0000_0001, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h7FFF_FFFF, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h8000_0000, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h7FFF_FFFF, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h8000_0000, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'hC000_0000, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h7FFF_FFFF, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h8000_0000, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h0000_0000, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      // sizes below range clamp to 3x3, frame left open
      '{ 2, 32'h0000_8000, 1'b1, 1, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'hFFFF_8000, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h0000_7FFF, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0},
      '{-1, 32'h0000_0001, 1'b0, 0, 0, 32'h0, 0, 0, 32'h0, 0, 0}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("grid_diffusion_decay_step: mismatch");
      $finish;
   end

   function automatic int unsigned clamp_size(input logic [gdd_pkg::SIZE_W-1:0] v,
                                              input int unsigned hi);
      if (v < gdd_pkg::SIZE_MIN) return 32'(gdd_pkg::SIZE_MIN);
      if (32'(v) > hi) return hi;
      return 32'(v);
   endfunction

   // position the next sample lands on, after the wrap rules
   function automatic void locate_cell(input logic fs, output int unsigned col,
                                       output int unsigned row);
      int unsigned len;
      int unsigned rows;
      len  = clamp_size(row_length, MAX_ROW_LEN);
      rows = clamp_size(row_count, MAX_ROWS);
      col  = fs ? 0 : col_pos;
      row  = fs ? 0 : row_pos;
      if (col >= len) begin
         col = 0;
         row++;
      end
      if (row >= rows) row = 0;
   endfunction

   function automatic bit is_interior(input int unsigned col, input int unsigned row);
      return row >= 2 && col != 0 && col != clamp_size(row_length, MAX_ROW_LEN) - 1;
   endfunction

   // a sample without frame_start here would read a line buffer entry never written
   function automatic bit touches_unwritten();
      int unsigned col;
      int unsigned row;
      locate_cell(1'b0, col, row);
      if (row == 0) return 0;
      if (!newer_ok[col]) return 1;
      if (is_interior(col, row)) return !older_ok[col] || !newer_ok[col + 1];
      return 0;
   endfunction

   function automatic logic [31:0] diffuse(input logic signed [31:0] ctr,
                                           input logic signed [31:0] up,
                                           input logic signed [31:0] down,
                                           input logic signed [31:0] west,
                                           input logic signed [31:0] east);
      longint lap;
      longint acc;
      longint r;
      lap = longint'(up) + longint'(down) + longint'(west) + longint'(east)
          - STENCIL_WEIGHT * longint'(ctr);
      acc = longint'(ctr) * 65536 + longint'(diffusion_gain) * lap
          - longint'(decay_gain) * longint'(ctr);
      // round half up, then clip to 32 bits
      r = (acc + 32768) >>> 16;
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return r[31:0];
   endfunction

   function automatic void step_grid(input logic [31:0] sample, input logic fs,
                                     output int n, output cell_result_type r0,
                                     output cell_result_type r1);
      int unsigned len;
      int unsigned rows;
      int unsigned col;
      int unsigned row;
      logic signed [31:0] ctr;
      len  = clamp_size(row_length, MAX_ROW_LEN);
      rows = clamp_size(row_count, MAX_ROWS);
      locate_cell(fs, col, row);
      n  = 0;
      r0 = '0;
      r1 = '0;
      if (row >= 1) begin
         ctr = newer_rows[col];
         r0.value = is_interior(col, row)
                  ? diffuse(ctr, older_rows[col], sample, left_hold, newer_rows[col + 1])
                  : ctr;
         r0.run_last = (row != rows - 1);
         n = 1;
      end
      // last row also hands its own sample straight out
      if (row == rows - 1) begin
         r1 = '{value: sample, run_last: 1'b1, frame_end: (col == len - 1)};
         n = 2;
      end
      left_hold       = newer_rows[col];
      older_rows[col] = newer_rows[col];
      older_ok[col]   = newer_ok[col];
      newer_rows[col] = sample;
      newer_ok[col]   = 1'b1;
      col++;
      if (col >= len) begin
         col = 0;
         row = (row + 1 >= rows) ? 0 : row + 1;
      end
      col_pos = col;
      row_pos = row;
   endfunction

   function automatic void expect_cell(input cell_result_type c);
      pending_cells.insert(pending_cells.size(), c);
   endfunction

   // entered and left at a falling edge
   task automatic send_item(input logic [31:0] s, input logic fs, input bit typed,
                            input int tn, input cell_result_type t0,
                            input cell_result_type t1);
      int n;
      cell_result_type p0;
      cell_result_type p1;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= fs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_grid(s, fs, n, p0, p1);
      if (typed) begin
         n  = tn;
         p0 = t0;
         p1 = t1;
      end
      if (n > 0) expect_cell(p0);
      if (n > 1) expect_cell(p1);
      samples_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                  : $urandom_range(0, 30);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [gdd_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [gdd_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         gdd_pkg::CSR_DIFFUSION_GAIN: diffusion_gain = data[gdd_pkg::DGAIN_W-1:0];
         gdd_pkg::CSR_DECAY_GAIN:     decay_gain     = data[gdd_pkg::KGAIN_W-1:0];
         gdd_pkg::CSR_ROW_LENGTH:     row_length     = data[gdd_pkg::SIZE_W-1:0];
         gdd_pkg::CSR_ROW_COUNT:      row_count      = data[gdd_pkg::SIZE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic program_grid(input grid_setting_type cfg, input logic [3:0] mask);
      wait_quiet();
      if (mask[0]) write_csr(gdd_pkg::CSR_DIFFUSION_GAIN, cfg.diffusion);
      if (mask[1]) write_csr(gdd_pkg::CSR_DECAY_GAIN, cfg.decay);
      if (mask[2]) write_csr(gdd_pkg::CSR_ROW_LENGTH, cfg.length);
      if (mask[3]) write_csr(gdd_pkg::CSR_ROW_COUNT, cfg.count);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [gdd_pkg::CSR_DATA_W-1:0] pick_size(input int unsigned top);
      int unsigned k;
      k = $urandom_range(0, 19);
      if (k < 14) return 16'($urandom_range(3, top));
      if (k < 16) return 16'($urandom_range(0, 2));
      if (k < 19) return 16'($urandom_range(top + 1, 3 * top));
      // bits above the register width are dropped
      return {5'($urandom), 11'($urandom_range(3, top))};
   endfunction

   function automatic grid_setting_type pick_setting();
      grid_setting_type cfg;
      case ($urandom_range(0, 3))
         0:       cfg.diffusion = 16'd0;
         1:       cfg.diffusion = 16'd16384;
         2:       cfg.diffusion = 16'($urandom_range(0, 16384));
         default: cfg.diffusion = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       cfg.decay = 16'd0;
         1:       cfg.decay = 16'hFFFF;
         2:       cfg.decay = 16'($urandom);
         default: cfg.decay = 16'($urandom_range(0, 2048));
      endcase
      cfg.length = pick_size(12);
      cfg.count  = pick_size(8);
      return cfg;
   endfunction

   // receiver pacing, independent of the sender
   initial begin : rsp_pacer
      pace_mode_type mode;
      int span;
      int k;
      forever begin
         mode = pace_mode_type'($urandom_range(0, 3));
         span = $urandom_range(16, 300);
         for (k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               PACE_OPEN:    rsp_tready <= 1'b1;
               PACE_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
               PACE_QUARTER: rsp_tready <= (k % 4 == 3);
               default:      rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : result_check
      cell_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cells.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t: unexpected transaction value %h last %b end %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = pending_cells.pop_front();
            cells_checked++;
            if (rsp_tdata !== want.value) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: value expected %h actual %h", $time, want.value, rsp_tdata);
            end
            if (rsp_tlast !== want.run_last) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                           rsp_tlast);
            end
            if (rsp_tuser !== want.frame_end) begin
               mismatches++;
               if (mismatches <= REPORT_CAP)
                  $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                           rsp_tuser);
            end
         end
      end
   end

   initial begin : stimulus
      directed_row_type d;
      int unsigned   frame_cells;
      int unsigned   quota;
      int unsigned   random_sent;
      int unsigned   col;
      int unsigned   row;
      int unsigned   i;
      logic          fs;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(negedge clock);

      foreach (directed_rows[j]) begin
         d = directed_rows[j];
         if (d.setting >= 0) program_grid(directed_settings[d.setting], 4'hF);
         send_item(d.sample, d.frame_start, d.typed, d.count,
                   '{d.v0, d.l0, d.e0}, '{d.v1, d.l1, d.e1});
      end

      // mostly whole frames on small grids, phases sometimes end mid-frame
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         program_grid(pick_setting(), 4'($urandom_range(1, 15)));
         frame_cells = clamp_size(row_length, MAX_ROW_LEN) * clamp_size(row_count, MAX_ROWS);
         quota = frame_cells * $urandom_range(1, 3);
         if ($urandom_range(0, 9) < 3) quota += $urandom_range(1, frame_cells - 1);
         if (quota > RANDOM_ITEMS - random_sent) quota = RANDOM_ITEMS - random_sent;
         for (i = 0; i < quota; i++) begin
            locate_cell(1'b0, col, row);
            if (i == 0) fs = ($urandom_range(0, 9) < 7);
            else if (col == 0 && row == 0) fs = 1'($urandom_range(0, 1));
            else fs = ($urandom_range(0, 99) < 2);
            if (!fs && touches_unwritten()) fs = 1'b1;
            send_item(pick_sample(), fs, 0, 0, '0, '0);
         end
         random_sent += quota;
      end

      wait_quiet();
      $display("ran %0d samples over %0d register settings, %0d result cells compared",
               samples_sent, settings_used, cells_checked);
      $display("grids from 3x3 up to 36 wide and 24 tall, undersized settings clamped, "
               , "gains from zero to full scale");
      if (mismatches == 0 && pending_cells.size() == 0) begin
         $display("grid_diffusion_decay_step: match");
      end else begin
         $display("grid_diffusion_decay_step: mismatch");
      end
      $finish;
   end

endmodule
